// File: sv/rpj_pkg.sv
// Shared types, constants and helpers for the disparity reprojection core.
// Used by every module of the block; depends on nothing.
package rpj_pkg;

   // Matrix register file: eight 64-bit words, two Q16.16 entries each.
   localparam int NUM_REGS    = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 64;

   // Field widths.
   localparam int COL_W   = 11;
   localparam int ROW_W   = 11;
   localparam int DISP_W  = 16;
   localparam int MASK_W  = 8;
   localparam int COLOR_W = 24;
   localparam int POINT_W = 32;

   // Product and Q.20 row-sum widths; each sum stays below 2^48 in magnitude.
   localparam int PROD_W = 48;
   localparam int SUM_W  = 50;
   localparam int MAG_W  = 48;
   localparam int NUM_W  = 64;
   localparam int QUO_W  = 32;

   localparam int QUEUE_DEPTH = 4;

   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 2048;

   localparam logic [MASK_W-1:0] MASK_USED = 8'd255;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_SKIP  = 2'd1,
      STATUS_WZERO = 2'd2
   } status_type;

   // Word handed from the front end to the back end through the queue.
   typedef struct packed {
      logic                        skip;
      logic signed [SUM_W-1:0]     sum_x;
      logic signed [SUM_W-1:0]     sum_y;
      logic signed [SUM_W-1:0]     sum_z;
      logic signed [SUM_W-1:0]     sum_w;
      logic        [COLOR_W-1:0]   color_rgb;
   } queue_word_type;

   // Queue fill status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Magnitude of a row sum; it always fits in MAG_W bits.
   function automatic logic [MAG_W-1:0] sum_mag(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] m;
      m = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
      return m[MAG_W-1:0];
   endfunction

endpackage

// File: sv/rpj_front.sv
// Front end: matrix registers, pixel classification, products and row sums.
// Depends on rpj_pkg; feeds rpj_queue.
module rpj_front #(
   parameter int MAX_WIDTH  = rpj_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = rpj_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [rpj_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [rpj_pkg::CSR_DATA_W-1:0]         csr_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [rpj_pkg::COL_W-1:0]              req_pixel_col,
   input  logic [rpj_pkg::ROW_W-1:0]              req_pixel_row,
   input  logic signed [rpj_pkg::DISP_W-1:0]      req_disparity,
   input  logic [rpj_pkg::MASK_W-1:0]             req_mask_value,
   input  logic [rpj_pkg::COLOR_W-1:0]            req_color_bgr,
   input  rpj_pkg::queue_status_type              queue_status,
   output logic                                   queue_push,
   output rpj_pkg::queue_word_type                queue_word
);
   import rpj_pkg::*;

   localparam int BOUND_W = 14;

   logic [CSR_DATA_W-1:0]   mat_ff [NUM_REGS];

   logic                    s1_valid_ff;
   logic                    s1_skip_ff;
   logic [COLOR_W-1:0]      s1_color_ff;
   logic signed [PROD_W-1:0] s1_prod_ff [4][4];
   logic signed [PROD_W-1:0] s1_prod_in [4][4];
   logic                    s1_skip_in;

   logic                    s2_valid_ff;
   queue_word_type          s2_word_ff;
   queue_word_type          s2_word_in;

   logic                    front_en;

   // The whole front advances unless its last word cannot enter the queue.
   assign front_en   = !(s2_valid_ff && queue_status.full);
   assign req_stall  = !front_en;
   assign queue_push = s2_valid_ff && !queue_status.full;
   assign queue_word = s2_word_ff;

   // Matrix register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (csr_write && (csr_index < CSR_INDEX_W'(NUM_REGS))) begin
         mat_ff[csr_index[$clog2(NUM_REGS)-1:0]] <= csr_data;
      end
   end

   // Classification and the sixteen matrix-by-vector products.
   always_comb begin
      logic signed [POINT_W-1:0] m;
      logic signed [PROD_W-1:0]  term;
      s1_skip_in = (req_mask_value != MASK_USED) || (req_disparity == '0) ||
                   ({3'b0, req_pixel_col} >= BOUND_W'(MAX_WIDTH)) ||
                   ({3'b0, req_pixel_row} >= BOUND_W'(MAX_HEIGHT));
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            m = mat_ff[r*2 + c/2][(c%2)*32 +: 32];
            case (c)
               0:       term = PROD_W'($signed({1'b0, req_pixel_col}));
               1:       term = PROD_W'($signed({1'b0, req_pixel_row}));
               2:       term = PROD_W'(req_disparity);
               default: term = PROD_W'(1);
            endcase
            s1_prod_in[r][c] = PROD_W'(m) * term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (front_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s1_skip_ff  <= s1_skip_in;
         s1_color_ff <= {req_color_bgr[7:0], req_color_bgr[15:8], req_color_bgr[23:16]};
         s1_prod_ff  <= s1_prod_in;
      end
   end

   // Row sums in Q.20: column, row and constant terms carry a factor of 16.
   always_comb begin
      logic signed [SUM_W-1:0] sums [4];
      for (int r = 0; r < 4; r++) begin
         sums[r] = (SUM_W'(s1_prod_ff[r][0]) <<< 4) + (SUM_W'(s1_prod_ff[r][1]) <<< 4)
                 + SUM_W'(s1_prod_ff[r][2]) + (SUM_W'(s1_prod_ff[r][3]) <<< 4);
      end
      s2_word_in.skip      = s1_skip_ff;
      s2_word_in.sum_x     = sums[0];
      s2_word_in.sum_y     = sums[1];
      s2_word_in.sum_z     = sums[2];
      s2_word_in.sum_w     = sums[3];
      s2_word_in.color_rgb = s1_color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (front_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s2_word_ff <= s2_word_in;
      end
   end

endmodule

// File: sv/rpj_queue.sv
// Short queue between the front end and the back end.
// Depends on rpj_pkg for the word type and depth.
module rpj_queue #(
   parameter int DEPTH = rpj_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rpj_pkg::queue_word_type    push_word,
   input  logic                       pop,
   output rpj_pkg::queue_word_type    pop_word,
   output rpj_pkg::queue_status_type  status
);
   import rpj_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_word_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_word     = slot_ff[rd_ptr_ff];

   // Pointer wrap and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// File: sv/rpj_back.sv
// Back end: magnitudes, pipelined restoring division, rounding and saturation.
// Depends on rpj_pkg; drains rpj_queue and drives the result channel.
module rpj_back (
   input  logic                               clock,
   input  logic                               reset,
   input  rpj_pkg::queue_status_type          queue_status,
   input  rpj_pkg::queue_word_type            queue_word,
   output logic                               queue_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic signed [rpj_pkg::POINT_W-1:0] rsp_point_x,
   output logic signed [rpj_pkg::POINT_W-1:0] rsp_point_y,
   output logic signed [rpj_pkg::POINT_W-1:0] rsp_point_z,
   output logic [rpj_pkg::COLOR_W-1:0]        rsp_color_rgb
);
   import rpj_pkg::*;

   typedef struct packed {
      logic                        valid;
      status_type                  status;
      logic [2:0]                  neg;
      logic [2:0]                  sat;
      logic [2:0][NUM_W-1:0]       rem;
      logic [2:0][QUO_W-1:0]       quo;
      logic [MAG_W-1:0]            dm;
      logic [COLOR_W-1:0]          color;
   } div_stage_type;

   div_stage_type          st_ff [QUO_W+1];
   div_stage_type          st_in [QUO_W+1];

   logic                   out_valid_ff;
   logic [1:0]             out_status_ff, out_status_in;
   logic [2:0][POINT_W-1:0] out_point_ff, out_point_in;
   logic [COLOR_W-1:0]     out_color_ff, out_color_in;

   logic                   back_en;

   // The back end moves as one pipeline whenever the output can take a word.
   assign back_en   = !(out_valid_ff && rsp_stall);
   assign queue_pop = back_en && !queue_status.empty;

   // Signs, magnitudes and the quotient-overflow check for each axis.
   always_comb begin
      logic signed [SUM_W-1:0] num [3];
      logic [MAG_W-1:0]        dm;
      logic [NUM_W-1:0]        n;
      num[0] = queue_word.sum_x;
      num[1] = queue_word.sum_y;
      num[2] = queue_word.sum_z;
      dm = sum_mag(queue_word.sum_w);
      st_in[0].valid = !queue_status.empty;
      st_in[0].dm    = dm;
      st_in[0].color = queue_word.color_rgb;
      if (queue_word.skip) begin
         st_in[0].status = STATUS_SKIP;
      end else if (queue_word.sum_w == '0) begin
         st_in[0].status = STATUS_WZERO;
      end else begin
         st_in[0].status = STATUS_OK;
      end
      for (int a = 0; a < 3; a++) begin
         n = {sum_mag(num[a]), 16'b0};
         st_in[0].neg[a] = num[a][SUM_W-1] ^ queue_word.sum_w[SUM_W-1];
         st_in[0].sat[a] = {16'b0, n[NUM_W-1:32]} >= dm;
         st_in[0].rem[a] = n;
         st_in[0].quo[a] = '0;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int B = QUO_W - 1 - k;

      always_comb begin
         st_in[k+1] = st_ff[k];
         for (int a = 0; a < 3; a++) begin
            if ((st_ff[k].rem[a] >> B) >= NUM_W'(st_ff[k].dm)) begin
               st_in[k+1].rem[a]    = st_ff[k].rem[a] - (NUM_W'(st_ff[k].dm) << B);
               st_in[k+1].quo[a][B] = 1'b1;
            end
         end
      end
   end

   for (genvar k = 0; k <= QUO_W; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k].valid <= 1'b0;
         end else if (back_en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // Round to nearest, ties away from zero, then apply sign and saturate.
   always_comb begin
      logic                 rnd;
      logic [QUO_W:0]       q1;
      div_stage_type        s;
      s = st_ff[QUO_W];
      out_status_in = s.status;
      out_color_in  = (s.status == STATUS_OK) ? s.color : '0;
      for (int a = 0; a < 3; a++) begin
         rnd = {1'b0, s.rem[a][MAG_W-1:0], 1'b0} >= {2'b0, s.dm};
         q1  = {1'b0, s.quo[a]} + {{QUO_W{1'b0}}, rnd};
         if (s.status != STATUS_OK) begin
            out_point_in[a] = '0;
         end else if (s.neg[a]) begin
            if (s.sat[a] || q1 >= (QUO_W+1)'(33'h0_8000_0000)) begin
               out_point_in[a] = 32'h8000_0000;
            end else begin
               out_point_in[a] = POINT_W'(-q1);
            end
         end else begin
            if (s.sat[a] || q1 > (QUO_W+1)'(33'h0_7FFF_FFFF)) begin
               out_point_in[a] = 32'h7FFF_FFFF;
            end else begin
               out_point_in[a] = q1[POINT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (back_en) begin
         out_valid_ff <= st_ff[QUO_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         out_status_ff <= out_status_in;
         out_point_ff  <= out_point_in;
         out_color_ff  <= out_color_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_point_x   = out_point_ff[0];
   assign rsp_point_y   = out_point_ff[1];
   assign rsp_point_z   = out_point_ff[2];
   assign rsp_color_rgb = out_color_ff;

endmodule

// File: sv/disparity_to_point_reprojection_core.sv
// Top level of the disparity-to-point reprojection core.
// Depends on rpj_pkg, rpj_front, rpj_queue and rpj_back.
//
// Usage: software writes the 4x4 Q16.16 matrix through the csr_ port, two
// entries per 64-bit word, while the core is idle. Pixels arrive on the req_
// channel and each yields exactly one result word on the rsp_ channel, in
// order. A word moves when valid is high and stall is low.
// Throughput is one pixel per cycle while rsp_stall is low. With an empty
// queue, a pixel passes two front stages (products, row sums), one queue
// slot, a magnitude stage, 32 restoring-division stages (one quotient bit
// each) and the round and saturate output register before rsp_valid rises.
// When rsp_stall is held, the back pipeline freezes, the four-entry queue
// fills, then the front freezes and req_stall rises; no word is dropped.
// Synchronous reset clears all matrix entries to zero and empties every
// stage and the queue; the core accepts a pixel in the first cycle after.
module disparity_to_point_reprojection_core #(
   parameter int MAX_WIDTH  = rpj_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = rpj_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [rpj_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rpj_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rpj_pkg::COL_W-1:0]          req_pixel_col,
   input  logic [rpj_pkg::ROW_W-1:0]          req_pixel_row,
   input  logic signed [rpj_pkg::DISP_W-1:0]  req_disparity,
   input  logic [rpj_pkg::MASK_W-1:0]         req_mask_value,
   input  logic [rpj_pkg::COLOR_W-1:0]        req_color_bgr,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic signed [rpj_pkg::POINT_W-1:0] rsp_point_x,
   output logic signed [rpj_pkg::POINT_W-1:0] rsp_point_y,
   output logic signed [rpj_pkg::POINT_W-1:0] rsp_point_z,
   output logic [rpj_pkg::COLOR_W-1:0]        rsp_color_rgb
);
   import rpj_pkg::*;

   logic              queue_push;
   logic              queue_pop;
   queue_word_type    push_word;
   queue_word_type    pop_word;
   queue_status_type  queue_status;

   rpj_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .req_disparity  (req_disparity),
      .req_mask_value (req_mask_value),
      .req_color_bgr  (req_color_bgr),
      .queue_status   (queue_status),
      .queue_push     (queue_push),
      .queue_word     (push_word)
   );

   rpj_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_word (push_word),
      .pop       (queue_pop),
      .pop_word  (pop_word),
      .status    (queue_status)
   );

   rpj_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .queue_word    (pop_word),
      .queue_pop     (queue_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_point_z   (rsp_point_z),
      .rsp_color_rgb (rsp_color_rgb)
   );

`ifndef NO_ASSERTIONS
   // The front never pushes into a full queue, and the back never pops an empty one.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      queue_push |-> !queue_status.full || queue_pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_status.empty)
      else $error("queue pop while empty");

   // A result that is not a valid point carries zero point and color.
   a_zero_unless_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         (rsp_point_x == '0) && (rsp_point_y == '0) && (rsp_point_z == '0) &&
         (rsp_color_rgb == '0))
      else $error("nonzero payload on a skipped result");

   // The status code never takes the unused value.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_SKIP) ||
         (rsp_status == STATUS_WZERO))
      else $error("unused status code on the result channel");
`endif

endmodule

// File: sim/disparity_to_point_reprojection_core_tb.sv
// Self-checking testbench for the disparity-to-point reprojection core.
// Depends on rpj_pkg and disparity_to_point_reprojection_core.
// Directed and random pixels under several matrices, checked against a table or a predictor.
`timescale 1ns / 1ps

module disparity_to_point_reprojection_core_tb;
   import rpj_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int ITEMS_PER_PHASE = 262;

   typedef struct {
      logic [COL_W-1:0]         col;
      logic [ROW_W-1:0]         row;
      logic signed [DISP_W-1:0] disp;
      logic [MASK_W-1:0]        mask;
      logic [COLOR_W-1:0]       bgr;
   } pixel_type;

   typedef struct {
      status_type                 status;
      logic signed [POINT_W-1:0]  x;
      logic signed [POINT_W-1:0]  y;
      logic signed [POINT_W-1:0]  z;
      logic [COLOR_W-1:0]         rgb;
   } point_type;

   typedef struct {
      pixel_type  px;
      status_type st;
   } dir_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_data = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [COL_W-1:0]             req_pixel_col = '0;
   logic [ROW_W-1:0]             req_pixel_row = '0;
   logic signed [DISP_W-1:0]     req_disparity = '0;
   logic [MASK_W-1:0]            req_mask_value = '0;
   logic [COLOR_W-1:0]           req_color_bgr = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [1:0]                   rsp_status;
   logic signed [POINT_W-1:0]    rsp_point_x;
   logic signed [POINT_W-1:0]    rsp_point_y;
   logic signed [POINT_W-1:0]    rsp_point_z;
   logic [COLOR_W-1:0]           rsp_color_rgb;

   // Shadow of the matrix registers and the queue of expected points.
   logic [CSR_DATA_W-1:0] matrix_words [NUM_REGS];
   logic [31:0]           entry_val [16];
   point_type             expected_points [$];
   int                    error_count = 0;
   int                    cycle_count = 0;
   int                    zero_disp = 0;
   bit                    source_idle_on = 1'b1;
   bit                    sink_idle_on = 1'b1;
   int                    sink_hold = 0;
   int                    sink_roll;
   dir_row_type           dir_table [13];

   disparity_to_point_reprojection_core dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic longint matrix_entry(int r, int c);
      logic [CSR_DATA_W-1:0] w;
      logic signed [31:0] e;
      w = matrix_words[r * 2 + c / 2];
      e = c[0] ? w[63:32] : w[31:0];
      return longint'(e);
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   // Q16.16 quotient, rounded to nearest with ties away from zero, saturated.
   function automatic logic [31:0] quotient_q16(longint num, longint den);
      bit neg;
      longint unsigned n, dm, q, r;
      neg = (num < 0) != (den < 0);
      n = magnitude(num) << 16;
      dm = magnitude(den);
      q = n / dm;
      r = n % dm;
      if (r >= dm - r) q++;
      if (neg) begin
         if (q >= 64'h8000_0000) return 32'h8000_0000;
         return 32'(64'd0 - q);
      end
      if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return 32'(q);
   endfunction

   // Expected point for one pixel under the current matrix.
   function automatic point_type predict_point(pixel_type p);
      point_type res;
      longint sums [4];
      res = '{STATUS_SKIP, 0, 0, 0, 0};
      if (p.mask != MASK_USED || p.disp == 0 || p.col >= DEFAULT_MAX_WIDTH ||
          p.row >= DEFAULT_MAX_HEIGHT)
         return res;
      for (int r = 0; r < 4; r++)
         sums[r] = matrix_entry(r, 0) * longint'(p.col) * 16
                 + matrix_entry(r, 1) * longint'(p.row) * 16
                 + matrix_entry(r, 2) * longint'(p.disp)
                 + matrix_entry(r, 3) * 16;
      if (sums[3] == 0) begin
         res.status = STATUS_WZERO;
         return res;
      end
      res.status = STATUS_OK;
      res.x = quotient_q16(sums[0], sums[3]);
      res.y = quotient_q16(sums[1], sums[3]);
      res.z = quotient_q16(sums[2], sums[3]);
      res.rgb = {p.bgr[7:0], p.bgr[15:8], p.bgr[23:16]};
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_hold <= 0;
      end else if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
      end else begin
         sink_roll = $urandom_range(0, 99);
         if (!sink_idle_on || sink_roll < 55) begin
            rsp_stall <= 1'b0;
            sink_hold <= $urandom_range(0, 6);
         end else if (sink_roll < 92) begin
            rsp_stall <= 1'b1;
            sink_hold <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            sink_hold <= $urandom_range(10, 50);
         end
      end
   end

   // Result words are sampled mid-cycle, where inputs and outputs are settled.
   always @(negedge clock) begin
      point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected word status", rsp_status, 0);
         end else begin
            want = expected_points.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_point_x !== want.x) report_mismatch("point_x", rsp_point_x, want.x);
            if (rsp_point_y !== want.y) report_mismatch("point_y", rsp_point_y, want.y);
            if (rsp_point_z !== want.z) report_mismatch("point_z", rsp_point_z, want.z);
            if (rsp_color_rgb !== want.rgb)
               report_mismatch("color_rgb", rsp_color_rgb, want.rgb);
         end
      end
   end

   // Offers one pixel and waits for it to be taken; called at a rising edge.
   task automatic send_pixel(pixel_type p, bit typed, point_type typed_point);
      bit stalled;
      int gap;
      req_valid <= 1'b1;
      req_pixel_col <= p.col;
      req_pixel_row <= p.row;
      req_disparity <= p.disp;
      req_mask_value <= p.mask;
      req_color_bgr <= p.bgr;
      forever begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
         if (!stalled) break;
      end
      expected_points.insert(expected_points.size(), typed ? typed_point : predict_point(p));
      gap = pick_gap(source_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lets the core drain, then loads the matrix from entry_val.
   task automatic program_matrix();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_write <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_data <= {entry_val[2 * i + 1], entry_val[2 * i]};
         matrix_words[i] = {entry_val[2 * i + 1], entry_val[2 * i]};
         @(posedge clock);
      end
      // A write to an unknown index must be ignored.
      csr_index <= CSR_INDEX_W'($urandom_range(NUM_REGS, 15));
      csr_data <= {$urandom, $urandom};
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Typical stereo reprojection; W vanishes at disparity zero_disp.
   task automatic fill_stereo();
      int cx, cy, f, inv_base, dz;
      cx = $urandom_range(0, 1024);
      cy = $urandom_range(0, 1024);
      f = $urandom_range(100, 2000);
      inv_base = $urandom_range(1, 65536);
      dz = $urandom_range(1, 50);
      foreach (entry_val[i]) entry_val[i] = '0;
      entry_val[0] = 32'h0001_0000;
      entry_val[3] = 32'(-(cx * 65536));
      entry_val[5] = 32'h0001_0000;
      entry_val[7] = 32'(-(cy * 65536));
      entry_val[11] = 32'(f * 65536);
      entry_val[14] = 32'(inv_base);
      entry_val[15] = 32'(-(inv_base * dz));
      zero_disp = 16 * dz;
   endtask

   function automatic pixel_type random_pixel();
      pixel_type p;
      int r;
      p.col = COL_W'($urandom);
      p.row = ROW_W'($urandom);
      p.bgr = COLOR_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 8) p.disp = 0;
      else if (r < 18 && zero_disp != 0) p.disp = DISP_W'(zero_disp);
      else p.disp = DISP_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 85) p.mask = MASK_USED;
      else if (r < 90) p.mask = MASK_W'(MASK_USED - 1);
      else p.mask = MASK_W'($urandom);
      return p;
   endfunction

   initial begin
      point_type typed_point;
      foreach (matrix_words[i]) matrix_words[i] = '0;

      // Zero matrix after reset: used pixels have W zero, others are skipped.
      dir_table[0]  = '{'{11'd0, 11'd0, 16'sd16, 8'd255, 24'hFFFFFF}, STATUS_WZERO};
      dir_table[1]  = '{'{11'd2047, 11'd2047, 16'sd32767, 8'd255, 24'h000000}, STATUS_WZERO};
      dir_table[2]  = '{'{11'd2047, 11'd0, -16'sd32768, 8'd255, 24'h123456}, STATUS_WZERO};
      dir_table[3]  = '{'{11'd5, 11'd7, 16'sd1, 8'd255, 24'hA5A5A5}, STATUS_WZERO};
      dir_table[4]  = '{'{11'd5, 11'd7, -16'sd1, 8'd255, 24'h5A5A5A}, STATUS_WZERO};
      dir_table[5]  = '{'{11'd10, 11'd20, 16'sd0, 8'd255, 24'h00FF00}, STATUS_SKIP};
      dir_table[6]  = '{'{11'd10, 11'd20, 16'sd0, 8'd0, 24'hFF00FF}, STATUS_SKIP};
      dir_table[7]  = '{'{11'd10, 11'd20, 16'sd100, 8'd0, 24'hFFFFFF}, STATUS_SKIP};
      dir_table[8]  = '{'{11'd10, 11'd20, 16'sd100, 8'd254, 24'hFFFFFF}, STATUS_SKIP};
      dir_table[9]  = '{'{11'd10, 11'd20, 16'sd100, 8'd127, 24'h0F0F0F}, STATUS_SKIP};
      dir_table[10] = '{'{11'd0, 11'd2047, -16'sd16, 8'd255, 24'hAA55AA}, STATUS_WZERO};
      dir_table[11] = '{'{11'd1024, 11'd512, 16'sd800, 8'd255, 24'h010203}, STATUS_WZERO};
      dir_table[12] = '{'{11'd2047, 11'd2047, 16'sd0, 8'd254, 24'hFFFFFF}, STATUS_SKIP};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows with the result typed in, under the reset matrix.
      foreach (dir_table[i]) begin
         typed_point = '{dir_table[i].st, 0, 0, 0, 0};
         send_pixel(dir_table[i].px, 1'b1, typed_point);
      end

      // Same rows again under a stereo matrix, checked by the predictor.
      fill_stereo();
      program_matrix();
      foreach (dir_table[i]) send_pixel(dir_table[i].px, 1'b0, typed_point);
      send_pixel('{11'd0, 11'd0, DISP_W'(zero_disp), 8'd255, 24'hC0FFEE}, 1'b0, typed_point);

      // Random phases over several matrices, extremes among them.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: fill_stereo();
            1: foreach (entry_val[i]) entry_val[i] = $urandom;
            2: foreach (entry_val[i]) entry_val[i] = 32'h7FFF_FFFF;
            3: foreach (entry_val[i]) entry_val[i] = 32'h8000_0000;
            4: begin
               foreach (entry_val[i]) entry_val[i] = $urandom;
               for (int c = 12; c < 16; c++) entry_val[c] = 32'($urandom_range(0, 6) - 3);
            end
            default: fill_stereo();
         endcase
         if (phase >= 1 && phase <= 4) zero_disp = 0;
         source_idle_on = (phase != 2);
         sink_idle_on = (phase != 3);
         program_matrix();
         repeat (ITEMS_PER_PHASE) send_pixel(random_pixel(), 1'b0, typed_point);
      end

      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_points.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
sv/rpj_pkg.sv
sv/rpj_front.sv
sv/rpj_queue.sv
sv/rpj_back.sv
sv/disparity_to_point_reprojection_core.sv
sim/disparity_to_point_reprojection_core_tb.sv
